### rtl/col_pkg.sv
// shared constants, codes and types for the compacting ordered list
package col_pkg;

    // list geometry
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    // port field widths
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int IDX_W = 4;
    localparam int ST_W  = 3;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // width for position compares, wide enough for count and index
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // bits carried between the value port and a stored word
    localparam int COPY_W = (WORD_BITS < VAL_W) ? WORD_BITS : VAL_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_APPEND       = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_AT    = 2'd2;
    localparam logic [OP_W-1:0] OP_GET          = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_ZERO      = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    // per-cell control from the row controller
    typedef struct packed {
        logic live;          // cell holds a valid entry
        logic load;          // cell is the append slot
        logic past_idx;      // cell position at or after the request index
        logic del_by_value;  // remove by value in progress
        logic del_by_index;  // remove at index in progress
    } t_cell_ctrl;

endpackage

### rtl/col_cell.sv
// one list cell: holds a word, compares it, shifts from its right neighbor
module col_cell
    import col_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_neighbor,
    input  logic                 i_found,
    output logic                 o_found,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 w_hit;
    logic                 w_shift;

    // match against the search word, first match ripples along the row
    assign w_hit   = i_ctrl.live && (r_word == i_word);
    assign o_found = i_found || w_hit;

    // close the gap at and after the deleted position
    assign w_shift = (i_ctrl.del_by_value && o_found) ||
                     (i_ctrl.del_by_index && i_ctrl.past_idx);

    always_comb begin
        n_word = r_word;
        if (w_shift) begin
            n_word = i_neighbor;
        end else if (i_ctrl.load) begin
            n_word = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

### rtl/compacting_ordered_list_unit.sv
// compacting ordered list: a row of cells with append, remove and get
// timing: a result word is registered and appears in the cycle after its request word is accepted
// throughput: one request word per cycle; every cell compares and shifts in parallel,
//   so only a held result (output register taken late) slows intake
// reset: synchronous active low, clears the entry count and the output valid;
//   stored words stay undefined until written
module compacting_ordered_list_unit
    import col_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0] i_index,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_read_value,
    output logic [CNT_W-1:0] o_entry_count
);

    logic                 r_out_valid;
    logic [ST_W-1:0]      r_status;
    logic [VAL_W-1:0]     r_read_value;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [ST_W-1:0]      n_status;

    logic                 w_accept;
    logic [WORD_BITS-1:0] w_search;
    logic [CMP_W-1:0]     w_idx;
    logic [CMP_W-1:0]     w_cnt;
    logic                 w_out_range;
    logic                 w_del_value;
    logic                 w_del_index;
    logic                 w_do_append;
    logic [WORD_BITS-1:0] w_rd;
    logic [VAL_W-1:0]     w_rd_port;

    t_cell_ctrl           w_ctrl  [DEPTH];
    logic [WORD_BITS-1:0] w_word  [DEPTH];
    logic [WORD_BITS-1:0] w_nbr   [DEPTH];
    logic                 w_found [DEPTH+1];

    // handshake: take a word unless a result is held
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // value port to stored word width
    always_comb begin
        w_search                = '0;
        w_search[COPY_W-1:0]    = i_value[COPY_W-1:0];
    end

    assign w_idx       = CMP_W'(i_index);
    assign w_cnt       = CMP_W'(r_count);
    assign w_out_range = (w_idx >= w_cnt);

    // operation enables
    assign w_do_append = w_accept && (i_opcode == OP_APPEND) &&
                         (r_count < CNT_W'(DEPTH));
    assign w_del_value = w_accept && (i_opcode == OP_REMOVE_VALUE) &&
                         (w_search != '0);
    assign w_del_index = w_accept && (i_opcode == OP_REMOVE_AT) && !w_out_range;

    assign w_found[0] = 1'b0;

    // the row of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign w_ctrl[k].live         = (CMP_W'(k) < w_cnt);
        assign w_ctrl[k].load         = w_do_append && (CMP_W'(k) == w_cnt);
        assign w_ctrl[k].past_idx     = (CMP_W'(k) >= w_idx);
        assign w_ctrl[k].del_by_value = w_del_value;
        assign w_ctrl[k].del_by_index = w_del_index;

        if (k == DEPTH - 1) begin : g_last
            assign w_nbr[k] = '0;
        end else begin : g_mid
            assign w_nbr[k] = w_word[k+1];
        end

        col_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl[k]),
            .i_word     (w_search),
            .i_neighbor (w_nbr[k]),
            .i_found    (w_found[k]),
            .o_found    (w_found[k+1]),
            .o_word     (w_word[k])
        );
    end

    // get: select the addressed live cell
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_ctrl[k].live && (CMP_W'(k) == w_idx)) begin
                w_rd = w_rd | w_word[k];
            end
        end
    end

    always_comb begin
        w_rd_port             = '0;
        w_rd_port[COPY_W-1:0] = w_rd[COPY_W-1:0];
    end

    // status and next count
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        unique case (i_opcode)
            OP_APPEND: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE_VALUE: begin
                if (w_search == '0) begin
                    n_status = ST_ZERO;
                end else if (!w_found[DEPTH]) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (w_out_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_GET: begin
                if (w_out_range) begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_read_value <= ((i_opcode == OP_GET) && !w_out_range) ? w_rd_port : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_count;

endmodule

### rtl/col_checker.sv
// port-level checks for the compacting ordered list, bound to the top level
module col_checker
    import col_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [ST_W-1:0]  o_status,
    input logic [VAL_W-1:0] o_read_value,
    input logic [CNT_W-1:0] o_entry_count
);

    // entry count never passes the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    // a full refusal only when the list is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_entry_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // read word is zero unless the request succeeded
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_read_value == '0))
        else $error("read word on failed request");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) &&
                                  $stable(o_entry_count)))
        else $error("held result changed");

    // an accepted request word yields a result word in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted word without result");

endmodule

bind compacting_ordered_list_unit col_checker u_col_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_read_value  (o_read_value),
    .o_entry_count (o_entry_count)
);
